// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh : concurrent assertion helpers
// Clocked on clk, disabled while rst_n is low. ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg : shared types and constants of the load rebalancer
// Transfer structs and default sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prb_pkg;

    localparam int MAX_NODES_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [16:0] WEIGHT_ONE   = 17'h10000;
    localparam logic [16:0] WEIGHT_RESET = 17'h08000;
    localparam logic [19:0] OUT_MAX      = 20'hFFFFF;

    typedef struct packed {
        logic [15:0] node_items;
        logic [31:0] node_load;
        logic        last_node;
    } rec_t;

    typedef struct packed {
        logic [19:0] new_items;
        logic        sum_mismatch;
        logic        last_result;
    } res_t;

endpackage

// File: hw/rtl/proportional_load_rebalancer_core.sv
// ----------------------------------------------------------------------------
// proportional_load_rebalancer_core : proportional item rebalancer
// Records load at one per cycle; busy stays low until the final record.
// The set then runs up to 3n-1 divisions on the one shared restoring divider,
// then a blend pass of read, two products and add for each node.
// Results are read from the count store and then presented; the receiver cannot stall them.
// Reset clears control state and sets load_weight to 0.5; stores are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module proportional_load_rebalancer_core #(
    parameter int MAX_NODES = prb_pkg::MAX_NODES_DEF,
    parameter int FRAC_BITS = prb_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  prb_pkg::rec_t node_rec,
    output logic          done,
    output prb_pkg::res_t result,
    input  logic          cfg_we,
    input  logic [16:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Sizing
    // ------------------------------------------------------------------
    localparam int AW    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NW    = $clog2(MAX_NODES + 1);
    localparam int TI_W  = 16 + $clog2(MAX_NODES);      // item total
    localparam int TL_W  = 32 + $clog2(MAX_NODES);      // raw load total
    localparam int SH_W  = TI_W + FRAC_BITS;            // ideal share
    localparam int RW    = 16 + FRAC_BITS;              // segment fraction
    localparam int MA_W  = (FRAC_BITS > 17) ? FRAC_BITS : 17;
    localparam int MB_W  = (TL_W > SH_W) ? TL_W : SH_W;
    localparam int P_W   = MA_W + MB_W;
    localparam int DVD_W = TL_W + 16 + FRAC_BITS;       // divider dividend
    localparam int DVS_W = 32;
    localparam int DC_W  = $clog2(DVD_W + 1);
    localparam int NUM_W = 49;                          // segment load numerator
    localparam int HD_W  = SH_W + 17;
    localparam int BS_W  = SH_W + 18;
    localparam int V_W   = BS_W - 16 - FRAC_BITS;
    localparam int VX_W  = (V_W + 1 > 20) ? V_W + 1 : 21;
    localparam int BAL_W = FRAC_BITS + 1;
    localparam int NS_W  = 21 + AW;

    localparam logic [BAL_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [BAL_W:0]   HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    typedef enum logic [18:0] {
        S_IDLE      = 19'h00001,  // collecting records
        S_TGT       = 19'h00002,  // launch target / uniform share division
        S_TGT_W     = 19'h00004,
        S_SEG_CHK   = 19'h00008,  // next segment or end of this node's fill
        S_SEG_RD    = 19'h00010,
        S_SEG_TEST  = 19'h00020,  // skip empty segment, else high product
        S_SEG_M1    = 19'h00040,  // low product
        S_SEG_M2    = 19'h00080,  // launch segment load / items
        S_SEG_DW    = 19'h00100,
        S_PART_M    = 19'h00200,  // launch partial fraction division
        S_PART_DW   = 19'h00400,
        S_C_END     = 19'h00800,  // store share of the node being filled
        S_FILL_LAST = 19'h01000,  // last node takes what is left
        S_BL_RD     = 19'h02000,
        S_BL_M1     = 19'h04000,
        S_BL_M2     = 19'h08000,
        S_BL_ADD    = 19'h10000,  // blend, error diffusion, saturate
        S_EMIT_RD   = 19'h20000,
        S_EMIT_OUT  = 19'h40000   // result transfer
    } state_t;

    state_t state_reg, state_next;

    logic [16:0]      weight_reg, weight_next;
    logic [NW-1:0]    loaded_reg, loaded_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [TI_W-1:0]  tot_items_reg, tot_items_next;
    logic [TL_W-1:0]  tot_load_reg, tot_load_next;
    logic [NW-1:0]    seg_idx_reg, seg_idx_next;
    logic [NW-1:0]    node_idx_reg, node_idx_next;
    logic             fresh_reg, fresh_next;
    logic [RW-1:0]    cur_rem_reg, cur_rem_next;
    logic [TL_W-1:0]  tgt_rem_reg, tgt_rem_next;
    logic [TL_W-1:0]  target_reg, target_next;
    logic [SH_W-1:0]  acc_reg, acc_next;
    logic [SH_W-1:0]  assigned_reg, assigned_next;
    logic [SH_W-1:0]  uni_share_reg, uni_share_next;
    logic             uniform_reg, uniform_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [HD_W-1:0]  hold_reg, hold_next;
    logic [BAL_W-1:0] bal_reg, bal_next;
    logic [NS_W-1:0]  new_sum_reg, new_sum_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [P_W-1:0]   prod_reg, prod_next;

    // shared multiplier operands
    logic [MA_W-1:0]  mul_a;
    logic [MB_W-1:0]  mul_b;

    // shared restoring divider, one quotient bit per cycle
    logic [DVD_W-1:0] div_q_reg, div_q_next;
    logic [DVS_W-1:0] div_r_reg, div_r_next;
    logic [DVS_W-1:0] div_dvs_reg, div_dvs_next;
    logic [DC_W-1:0]  div_cnt_reg, div_cnt_next;
    logic             div_busy_reg, div_busy_next;
    logic             div_fin_reg, div_fin_next;
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic [DVS_W:0]   div_sh;
    logic [DVS_W:0]   div_sub;
    logic             div_ge;

    // stores
    logic [15:0]      item_mem  [MAX_NODES];
    logic [31:0]      load_mem  [MAX_NODES];
    logic [SH_W-1:0]  share_mem [MAX_NODES];
    logic [19:0]      count_mem [MAX_NODES];
    logic [15:0]      rd_items_reg;
    logic [31:0]      rd_load_reg;
    logic [SH_W-1:0]  rd_share_reg;
    logic [19:0]      rd_count_reg;

    logic             share_we;
    logic [AW-1:0]    share_wa;
    logic [SH_W-1:0]  share_wd;
    logic             count_we;

    // datapath terms
    logic             accept;
    logic             rec_final;
    logic [RW-1:0]    r_cur;
    logic [16:0]      w_eff;
    logic [SH_W-1:0]  share_sel;
    logic [BS_W-1:0]  blend_sum;
    logic [FRAC_BITS-1:0] frac;
    logic [V_W-1:0]   whole;
    logic [BAL_W-1:0] cost;
    logic             is_last;
    logic             round_up;
    logic [VX_W-1:0]  v_inc;
    logic [19:0]      v_sat;
    logic             seg_fits;
    logic [TL_W-1:0]  rem_after;
    logic [RW-1:0]    part;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign rec_final = node_rec.last_node || (loaded_reg == NW'(MAX_NODES - 1));

    assign r_cur     = fresh_reg ? {rd_items_reg, {FRAC_BITS{1'b0}}} : cur_rem_reg;
    assign w_eff     = (weight_reg > prb_pkg::WEIGHT_ONE) ? prb_pkg::WEIGHT_ONE : weight_reg;
    assign share_sel = uniform_reg ? uni_share_reg : rd_share_reg;

    // b = (share*w + (old << FRAC_BITS)*(1-w)) >> 16
    assign blend_sum = BS_W'(hold_reg) + BS_W'({prod_reg[32:0], {FRAC_BITS{1'b0}}});
    assign frac      = blend_sum[16 +: FRAC_BITS];
    assign whole     = blend_sum[BS_W-1:16+FRAC_BITS];
    assign cost      = ONE - {1'b0, frac};
    assign is_last   = ((node_idx_reg + NW'(1)) == n_reg);
    // middle nodes round up when the balance exceeds the missing part;
    // the last node rounds to nearest against the remaining balance
    assign round_up  = is_last ? (({2'b00, frac} + {1'b0, bal_reg}) > HALF)
                               : (cost < bal_reg);
    assign v_inc     = VX_W'(whole) + VX_W'(round_up);
    assign v_sat     = (v_inc > VX_W'(prb_pkg::OUT_MAX)) ? prb_pkg::OUT_MAX : v_inc[19:0];

    assign seg_fits  = (div_q_reg <= DVD_W'(tgt_rem_reg));
    assign rem_after = tgt_rem_reg - div_q_reg[TL_W-1:0];
    assign part      = (div_q_reg > DVD_W'(r_cur)) ? r_cur : div_q_reg[RW-1:0];

    assign div_sh    = {div_r_reg, div_q_reg[DVD_W-1]};
    assign div_sub   = div_sh - {1'b0, div_dvs_reg};
    assign div_ge    = (div_sh >= {1'b0, div_dvs_reg});

    assign done                = (state_reg == S_EMIT_OUT);
    assign result.new_items    = rd_count_reg;
    assign result.sum_mismatch = (NS_W'(tot_items_reg) != new_sum_reg);
    assign result.last_result  = is_last;

    // ------------------------------------------------------------------
    // Next-state and datapath control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        weight_next    = cfg_we ? cfg_data : weight_reg;
        loaded_next    = loaded_reg;
        n_next         = n_reg;
        tot_items_next = tot_items_reg;
        tot_load_next  = tot_load_reg;
        seg_idx_next   = seg_idx_reg;
        node_idx_next  = node_idx_reg;
        fresh_next     = fresh_reg;
        cur_rem_next   = cur_rem_reg;
        tgt_rem_next   = tgt_rem_reg;
        target_next    = target_reg;
        acc_next       = acc_reg;
        assigned_next  = assigned_reg;
        uni_share_next = uni_share_reg;
        uniform_next   = uniform_reg;
        num_next       = num_reg;
        hold_next      = hold_reg;
        bal_next       = bal_reg;
        new_sum_next   = new_sum_reg;
        addr_next      = addr_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_dvd        = '0;
        div_dvs        = '0;
        share_we       = 1'b0;
        share_wa       = node_idx_reg[AW-1:0];
        share_wd       = acc_reg;
        count_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tot_items_next = ((loaded_reg == '0) ? '0 : tot_items_reg)
                                     + TI_W'(node_rec.node_items);
                    tot_load_next  = ((loaded_reg == '0) ? '0 : tot_load_reg)
                                     + TL_W'(node_rec.node_load);
                    if (rec_final)
                    begin
                        n_next      = loaded_reg + NW'(1);
                        loaded_next = '0;
                        state_next  = S_TGT;
                    end
                    else
                    begin
                        loaded_next = loaded_reg + NW'(1);
                    end
                end
            end

            S_TGT:
            begin
                div_start    = 1'b1;
                uniform_next = (tot_load_reg == '0);
                div_dvd      = (tot_load_reg == '0)
                               ? DVD_W'({tot_items_reg, {FRAC_BITS{1'b0}}})
                               : DVD_W'(tot_load_reg);
                div_dvs      = DVS_W'(n_reg);
                state_next   = S_TGT_W;
            end

            S_TGT_W:
            begin
                if (div_fin_reg)
                begin
                    seg_idx_next  = '0;
                    node_idx_next = '0;
                    fresh_next    = 1'b1;
                    assigned_next = '0;
                    acc_next      = '0;
                    if (uniform_reg)
                    begin
                        uni_share_next = div_q_reg[SH_W-1:0];
                        bal_next       = '0;
                        new_sum_next   = '0;
                        addr_next      = '0;
                        state_next     = S_BL_RD;
                    end
                    else
                    begin
                        target_next  = div_q_reg[TL_W-1:0];
                        tgt_rem_next = div_q_reg[TL_W-1:0];
                        state_next   = (n_reg == NW'(1)) ? S_FILL_LAST : S_SEG_CHK;
                    end
                end
            end

            S_SEG_CHK:
            begin
                if (seg_idx_reg == n_reg)
                begin
                    state_next = S_C_END;
                end
                else
                begin
                    addr_next  = seg_idx_reg[AW-1:0];
                    state_next = S_SEG_RD;
                end
            end

            S_SEG_RD:
            begin
                state_next = S_SEG_TEST;
            end

            S_SEG_TEST:
            begin
                mul_a = MA_W'(r_cur[RW-1:FRAC_BITS]);
                mul_b = MB_W'(rd_load_reg);
                if (rd_items_reg == '0 || r_cur == '0)
                begin
                    seg_idx_next = seg_idx_reg + NW'(1);
                    fresh_next   = 1'b1;
                    state_next   = S_SEG_CHK;
                end
                else
                begin
                    state_next = S_SEG_M1;
                end
            end

            S_SEG_M1:
            begin
                num_next   = prod_reg[NUM_W-1:0];
                mul_a      = MA_W'(r_cur[FRAC_BITS-1:0]);
                mul_b      = MB_W'(rd_load_reg);
                state_next = S_SEG_M2;
            end

            S_SEG_M2:
            begin
                div_start  = 1'b1;
                div_dvd    = DVD_W'(num_reg + NUM_W'(prod_reg[FRAC_BITS +: 32]));
                div_dvs    = DVS_W'(rd_items_reg);
                state_next = S_SEG_DW;
            end

            S_SEG_DW:
            begin
                mul_a = MA_W'(rd_items_reg);
                mul_b = MB_W'(tgt_rem_reg);
                if (div_fin_reg)
                begin
                    if (seg_fits)
                    begin
                        acc_next     = acc_reg + SH_W'(r_cur);
                        tgt_rem_next = rem_after;
                        seg_idx_next = seg_idx_reg + NW'(1);
                        fresh_next   = 1'b1;
                        state_next   = (rem_after == '0) ? S_C_END : S_SEG_CHK;
                    end
                    else
                    begin
                        state_next = S_PART_M;
                    end
                end
            end

            S_PART_M:
            begin
                div_start  = 1'b1;
                div_dvd    = {prod_reg[TL_W+15:0], {FRAC_BITS{1'b0}}};
                div_dvs    = rd_load_reg;
                state_next = S_PART_DW;
            end

            S_PART_DW:
            begin
                if (div_fin_reg)
                begin
                    acc_next     = acc_reg + SH_W'(part);
                    cur_rem_next = r_cur - part;
                    fresh_next   = 1'b0;
                    tgt_rem_next = '0;
                    state_next   = S_C_END;
                end
            end

            S_C_END:
            begin
                share_we      = 1'b1;
                assigned_next = assigned_reg + acc_reg;
                node_idx_next = node_idx_reg + NW'(1);
                acc_next      = '0;
                tgt_rem_next  = target_reg;
                state_next    = ((node_idx_reg + NW'(2)) < n_reg) ? S_SEG_CHK : S_FILL_LAST;
            end

            S_FILL_LAST:
            begin
                share_we      = 1'b1;
                share_wa      = AW'(n_reg - NW'(1));
                share_wd      = {tot_items_reg, {FRAC_BITS{1'b0}}} - assigned_reg;
                node_idx_next = '0;
                bal_next      = '0;
                new_sum_next  = '0;
                addr_next     = '0;
                state_next    = S_BL_RD;
            end

            S_BL_RD:
            begin
                state_next = S_BL_M1;
            end

            S_BL_M1:
            begin
                mul_a      = MA_W'(w_eff);
                mul_b      = MB_W'(share_sel);
                state_next = S_BL_M2;
            end

            S_BL_M2:
            begin
                hold_next  = prod_reg[HD_W-1:0];
                mul_a      = MA_W'(prb_pkg::WEIGHT_ONE - w_eff);
                mul_b      = MB_W'(rd_items_reg);
                state_next = S_BL_ADD;
            end

            S_BL_ADD:
            begin
                count_we     = 1'b1;
                new_sum_next = new_sum_reg + NS_W'(v_sat);
                if (!is_last)
                begin
                    bal_next = round_up ? (bal_reg - cost) : (bal_reg + BAL_W'(frac));
                end
                if (is_last)
                begin
                    node_idx_next = '0;
                    addr_next     = '0;
                    state_next    = S_EMIT_RD;
                end
                else
                begin
                    node_idx_next = node_idx_reg + NW'(1);
                    addr_next     = AW'(node_idx_reg + NW'(1));
                    state_next    = S_BL_RD;
                end
            end

            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end

            S_EMIT_OUT:
            begin
                if (is_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    node_idx_next = node_idx_reg + NW'(1);
                    addr_next     = AW'(node_idx_reg + NW'(1));
                    state_next    = S_EMIT_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shared multiplier, registered product
    assign prod_next = {{MB_W{1'b0}}, mul_a} * {{MA_W{1'b0}}, mul_b};

    // divider step
    always_comb
    begin
        div_q_next    = div_q_reg;
        div_r_next    = div_r_reg;
        div_dvs_next  = div_dvs_reg;
        div_cnt_next  = div_cnt_reg;
        div_busy_next = div_busy_reg;
        div_fin_next  = 1'b0;
        if (div_start)
        begin
            div_q_next    = div_dvd;
            div_r_next    = '0;
            div_dvs_next  = div_dvs;
            div_cnt_next  = DC_W'(DVD_W);
            div_busy_next = 1'b1;
        end
        else if (div_busy_reg)
        begin
            div_q_next   = {div_q_reg[DVD_W-2:0], div_ge};
            div_r_next   = div_ge ? div_sub[DVS_W-1:0] : div_sh[DVS_W-1:0];
            div_cnt_next = div_cnt_reg - DC_W'(1);
            if (div_cnt_reg == DC_W'(1))
            begin
                div_busy_next = 1'b0;
                div_fin_next  = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            weight_reg   <= prb_pkg::WEIGHT_RESET;
            loaded_reg   <= '0;
            n_reg        <= '0;
            seg_idx_reg  <= '0;
            node_idx_reg <= '0;
            fresh_reg    <= 1'b1;
            uniform_reg  <= 1'b0;
            bal_reg      <= '0;
            div_cnt_reg  <= '0;
            div_busy_reg <= 1'b0;
            div_fin_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            weight_reg   <= weight_next;
            loaded_reg   <= loaded_next;
            n_reg        <= n_next;
            seg_idx_reg  <= seg_idx_next;
            node_idx_reg <= node_idx_next;
            fresh_reg    <= fresh_next;
            uniform_reg  <= uniform_next;
            bal_reg      <= bal_next;
            div_cnt_reg  <= div_cnt_next;
            div_busy_reg <= div_busy_next;
            div_fin_reg  <= div_fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tot_items_reg <= tot_items_next;
        tot_load_reg  <= tot_load_next;
        cur_rem_reg   <= cur_rem_next;
        tgt_rem_reg   <= tgt_rem_next;
        target_reg    <= target_next;
        acc_reg       <= acc_next;
        assigned_reg  <= assigned_next;
        uni_share_reg <= uni_share_next;
        num_reg       <= num_next;
        hold_reg      <= hold_next;
        new_sum_reg   <= new_sum_next;
        addr_reg      <= addr_next;
        prod_reg      <= prod_next;
        div_q_reg     <= div_q_next;
        div_r_reg     <= div_r_next;
        div_dvs_reg   <= div_dvs_next;
    end

    // stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_mem[loaded_reg[AW-1:0]] <= node_rec.node_items;
            load_mem[loaded_reg[AW-1:0]] <= node_rec.node_load;
        end
        if (share_we)
        begin
            share_mem[share_wa] <= share_wd;
        end
        if (count_we)
        begin
            count_mem[node_idx_reg[AW-1:0]] <= v_sat;
        end
        rd_items_reg <= item_mem[addr_reg];
        rd_load_reg  <= load_mem[addr_reg];
        rd_share_reg <= share_mem[addr_reg];
        rd_count_reg <= count_mem[addr_reg];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_ALWAYS(a_div_no_restart, !(div_start && div_busy_reg), "divider restarted")
    `ASSERT_ALWAYS(a_bal_range, bal_reg <= ONE, "diffusion balance above one")
    `ASSERT_ALWAYS(a_seg_bound, (state_reg != S_SEG_CHK) || (seg_idx_reg <= n_reg), "seg past set")
    `ASSERT_NEXT(a_last_frees, done && result.last_result, !busy, "busy after final result")

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench : proportional_load_rebalancer_core
// Sends node record sets through the record port and predicts each set's
// rebalanced counts with a fixed-point model of its own. Every result strobe
// is checked in node order. Load weight is changed only while the core idles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int NODES = 16;
    localparam int FRAC  = 16;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    prb_pkg::rec_t node_rec;
    logic          done;
    prb_pkg::res_t result;
    logic          cfg_we;
    logic [16:0]   cfg_data;

    proportional_load_rebalancer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .node_rec (node_rec),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // model state
    logic [16:0]   weight_reg;
    logic [15:0]   set_items [NODES];
    logic [31:0]   set_loads [NODES];
    int            set_count;
    prb_pkg::res_t expected_counts[$];
    int            errors;
    int            items_sent;
    int            burst_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("proportional_load_rebalancer_core test failed");
        $finish;
    end

    // Ideal shares, blend and error diffusion for one complete set of n records.
    function automatic void predict_rebalance(int n);
        bit [63:0] mask;
        bit [63:0] one;
        bit [63:0] tl, ti, target, rem, w, r, lv, seg, q, part;
        bit [63:0] b, f, v, bal, wt, new_sum, old_sum;
        bit [63:0] frac_left [NODES];
        bit [63:0] share [NODES];
        bit [63:0] counts [NODES];
        prb_pkg::res_t rr;
        mask = (64'd1 << FRAC) - 1;
        one  = 64'd1 << FRAC;
        tl = 0;
        ti = 0;
        for (int i = 0; i < n; i++)
        begin
            tl += set_loads[i];
            ti += set_items[i];
        end
        if (tl == 0)
        begin
            for (int i = 0; i < n; i++)
                share[i] = (ti << FRAC) / n;
        end
        else
        begin
            target = tl / n;
            for (int i = 0; i < n; i++)
            begin
                frac_left[i] = 64'(set_items[i]) << FRAC;
                share[i] = 0;
            end
            // greedy fill of nodes 0..n-2, whole segments where they fit
            for (int c = 0; c + 1 < n; c++)
            begin
                rem = target;
                for (int i = 0; i < n; i++)
                begin
                    w  = set_items[i];
                    r  = frac_left[i];
                    lv = set_loads[i];
                    if (w == 0 || r == 0)
                        continue;
                    seg = ((r >> FRAC) * lv + (((r & mask) * lv) >> FRAC)) / w;
                    if (seg <= rem)
                    begin
                        share[c] += r;
                        frac_left[i] = 0;
                        rem -= seg;
                    end
                    else
                    begin
                        q = rem * w;
                        part = ((q / lv) << FRAC) + (((q % lv) << FRAC) / lv);
                        if (part > r)
                            part = r;
                        share[c] += part;
                        frac_left[i] = r - part;
                        rem = 0;
                    end
                    if (rem == 0)
                        break;
                end
            end
            share[n-1] = 0;
            for (int i = 0; i < n; i++)
                share[n-1] += frac_left[i];
        end
        wt = (weight_reg > prb_pkg::WEIGHT_ONE) ? 64'(prb_pkg::WEIGHT_ONE) : 64'(weight_reg);
        bal = 0;
        new_sum = 0;
        old_sum = 0;
        for (int i = 0; i < n; i++)
        begin
            b = (share[i] * wt + ((64'(set_items[i]) << FRAC) * (64'h10000 - wt))) >> 16;
            f = b & mask;
            v = b >> FRAC;
            if (i + 1 < n)
            begin
                if (one - f < bal)
                begin
                    bal -= one - f;
                    v++;
                end
                else
                    bal += f;
            end
            else if (f + bal > (one >> 1))
                v++;
            if (v > 64'(prb_pkg::OUT_MAX))
                v = 64'(prb_pkg::OUT_MAX);
            counts[i] = v;
            new_sum += v;
            old_sum += set_items[i];
        end
        for (int i = 0; i < n; i++)
        begin
            rr.new_items    = counts[i][19:0];
            rr.sum_mismatch = (new_sum != old_sum);
            rr.last_result  = (i + 1 == n);
            expected_counts.push_back(rr);
        end
    endfunction

    // result checker: the core cannot be stalled, every strobe is a transfer
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_counts.size() == 0)
            begin
                $error("unexpected result transfer new_items=%0d", result.new_items);
                errors++;
            end
            else
            begin
                prb_pkg::res_t ex;
                ex = expected_counts.pop_front();
                if (result.new_items !== ex.new_items)
                begin
                    $error("new_items expected %0d actual %0d", ex.new_items, result.new_items);
                    errors++;
                end
                if (result.sum_mismatch !== ex.sum_mismatch)
                begin
                    $error("sum_mismatch expected %0d actual %0d",
                           ex.sum_mismatch, result.sum_mismatch);
                    errors++;
                end
                if (result.last_result !== ex.last_result)
                begin
                    $error("last_result expected %0d actual %0d",
                           ex.last_result, result.last_result);
                    errors++;
                end
            end
        end
    end

    // One record transfer; sender runs in random bursts with random gaps.
    task automatic send_rec(input logic [15:0] items, input logic [31:0] load,
                            input logic last);
        int gap;
        int slot;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        node_rec <= '{node_items: items, node_load: load, last_node: last};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        slot = (set_count >= NODES) ? NODES - 1 : set_count;
        set_items[slot] = items;
        set_loads[slot] = load;
        set_count = slot + 1;
        if (last || set_count >= NODES)
        begin
            predict_rebalance(set_count);
            set_count = 0;
        end
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_weight(input logic [16:0] value);
        wait_drain();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        weight_reg = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_load();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'($urandom_range(0, 3));
            2: return $urandom;
            3: return 32'($urandom_range(0, 32'h0004_0000));
            default: return 32'($urandom_range(32'h0000_8000, 32'h0010_0000));
        endcase
    endfunction

    function automatic logic [15:0] pick_items();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'($urandom);
            default: return 16'($urandom_range(1, 200));
        endcase
    endfunction

    task automatic random_set(input int n, input bit flag_last);
        for (int i = 0; i < n; i++)
            send_rec(pick_items(), pick_load(), flag_last && (i == n - 1));
    endtask

    task automatic test_extremes();
        send_rec(16'hFFFF, 32'hFFFF_FFFF, 1'b1);   // single node at full scale
        send_rec(16'd0, 32'd0, 1'b1);               // single empty node
        send_rec(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_rec(16'd1, 32'd1, 1'b1);
        wait_drain();
    endtask

    task automatic test_zero_load();
        send_rec(16'd7, 32'd0, 1'b0);
        send_rec(16'd3, 32'd0, 1'b0);
        send_rec(16'd5, 32'd0, 1'b1);
        wait_drain();
    endtask

    task automatic test_tiny_target();
        // total load below node count: target truncates to zero
        send_rec(16'd10, 32'd1, 1'b0);
        send_rec(16'd4, 32'd0, 1'b0);
        send_rec(16'd9, 32'd1, 1'b1);
        wait_drain();
    endtask

    task automatic test_empty_segment();
        send_rec(16'd0, 32'h0002_0000, 1'b0);
        send_rec(16'd12, 32'h0001_0000, 1'b0);
        send_rec(16'd0, 32'd0, 1'b1);
        wait_drain();
    endtask

    task automatic test_full_buffer();
        // sixteen records with no final flag close the set on their own
        for (int i = 0; i < NODES; i++)
            send_rec(16'(i * 3), 32'(i) << 16, 1'b0);
        wait_drain();
    endtask

    task automatic test_weights();
        logic [16:0] wset [4] = '{17'd0, 17'h10000, 17'h1FFFF, 17'd1};
        foreach (wset[k])
        begin
            set_weight(wset[k]);
            random_set(3, 1'b1);
        end
        wait_drain();
    endtask

    task automatic test_random();
        logic [16:0] wv;
        int n;
        while (items_sent < 225)
        begin
            case ($urandom_range(0, 3))
                0: wv = 17'($urandom_range(0, 17'h1FFFF));
                1: wv = 17'h10000;
                default: wv = 17'($urandom_range(0, 17'h10000));
            endcase
            set_weight(wv);
            for (int s = 0; s < 6 && items_sent < 225; s++)
            begin
                n = $urandom_range(0, 9);
                if (n == 0)
                    random_set(NODES, $urandom_range(0, 1));
                else
                    random_set($urandom_range(1, 6), 1'b1);
            end
        end
        wait_drain();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        node_rec   = '0;
        cfg_we     = 1'b0;
        cfg_data   = '0;
        weight_reg = prb_pkg::WEIGHT_RESET;
        set_count  = 0;
        errors     = 0;
        items_sent = 0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_extremes();
        test_zero_load();
        test_tiny_target();
        test_empty_segment();
        test_full_buffer();
        test_weights();
        test_random();

        if (errors == 0 && expected_counts.size() == 0)
            $display("proportional_load_rebalancer_core test passed");
        else
            $display("proportional_load_rebalancer_core test failed");
        $finish;
    end

endmodule

// File: proportional_load_rebalancer_core.f
+incdir+hw/rtl
hw/rtl/prb_pkg.sv
hw/rtl/proportional_load_rebalancer_core.sv
test/testbench.sv
